// ===== src/first_match_rule_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-match rule classifier.
// Both macros expect signals named clk and arst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_RULE_CLASSIFIER_DEFINES_SVH
`define FIRST_MATCH_RULE_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmrc_pkg
// Constants and codes shared by the first-match rule classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fmrc_pkg;

	// Default table depth and module id width.
	localparam int MAX_RULES_DEF   = 32;
	localparam int MODULE_BITS_DEF = 8;

	// Operation selector carried on the input tuser.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// Direction and verdict codes.
	localparam logic [1:0] DIR_BOTH       = 2'd2;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_DROP   = 2'd1;
	localparam logic [1:0] VERDICT_LOG    = 2'd2;
	localparam logic [1:0] ACTION_BAD     = 2'd3;

	// Status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Result word layout.
	localparam int RULE_INDEX_W = 5;
	localparam int COUNT_W      = 32;
	localparam int OUT_BITS     = 1 + 2 + 1 + RULE_INDEX_W + 4 * COUNT_W;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/first_match_rule_classifier.sv =====
// ----------------------------------------------------------------------------
// first_match_rule_classifier
// Firewall rule table with first-match classification and verdict totals.
// ----------------------------------------------------------------------------
// Add words append a rule to the table; check words scan the rules in
// insertion order with a single rule comparator that steps through the rule
// memory at one rule per clock. An add goes from idle to the result load and
// back to idle. A check compares one rule after another up to the first
// match, then does the hit counter read-modify-write, the result load and the
// return to idle; a check with no match compares every stored rule and then
// loads the result, and on an empty table it goes straight to the result load.
// The result is loaded into the output register at the same edge at which the
// block returns to idle; if the previous result still waits there, the block
// holds until it is taken. The block takes a new word while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_match_rule_classifier_defines.svh"

module first_match_rule_classifier
	import fmrc_pkg::*;
#(
	parameter int MAX_RULES   = MAX_RULES_DEF,
	parameter int MODULE_BITS = MODULE_BITS_DEF,
	localparam int MOD_W      = MODULE_BITS + 1,
	localparam int IN_BITS    = 4 + 2 * MOD_W,
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input words.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// tdata from bit 0: direction, action, source module, destination module,
	// zero pad.
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// tuser: op.
	input  wire logic                   s_tuser,
	// Result words.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tdata from bit 0: status, verdict, matched, rule_index, rule_hits,
	// dropped_total, logged_total, accepted_total, zero pad.
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int IDX_W   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W   = $clog2(MAX_RULES + 1);
	localparam int RIX_W   = (IDX_W > RULE_INDEX_W) ? IDX_W : RULE_INDEX_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_HIT  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [MOD_W-1:0] WILDCARD = '1;

	// Rule entry: dst, src, verdict, direction from the top down.
	typedef struct packed {
		logic [MOD_W-1:0] dst;
		logic [MOD_W-1:0] src;
		logic [1:0]       verdict;
		logic [1:0]       dir;
	} rule_t;

	// Rule table and hit counters.
	rule_t              rule_mem [MAX_RULES];
	logic [COUNT_W-1:0] hit_mem  [MAX_RULES];

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   used_q;
	logic [IDX_W-1:0]   idx_q;
	rule_t              rule_rd_q;
	logic [COUNT_W-1:0] hit_rd_q;

	logic [1:0]         req_dir_q;
	logic [MOD_W-1:0]   req_src_q;
	logic [MOD_W-1:0]   req_dst_q;

	logic               res_check_q;
	logic               res_status_q;
	logic [1:0]         res_verdict_q;
	logic               res_matched_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic [COUNT_W-1:0] res_hits_q;

	logic [COUNT_W-1:0] drop_cnt_q;
	logic [COUNT_W-1:0] log_cnt_q;
	logic [COUNT_W-1:0] accept_cnt_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Unpacked input fields.
	logic [1:0]       in_dir;
	logic [1:0]       in_act;
	logic [MOD_W-1:0] in_src;
	logic [MOD_W-1:0] in_dst;
	logic             in_fire;
	logic             tbl_full;

	assign in_dir   = s_tdata[1:0];
	assign in_act   = s_tdata[3:2];
	assign in_src   = s_tdata[4 +: MOD_W];
	assign in_dst   = s_tdata[4 + MOD_W +: MOD_W];
	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign tbl_full = (used_q == CNT_W'(MAX_RULES));

	// The shared rule comparator, applied to one stored rule per clock.
	logic rule_hit;
	logic scan_last;

	assign rule_hit = ((rule_rd_q.dir == DIR_BOTH) || (rule_rd_q.dir == req_dir_q)) &&
		((rule_rd_q.src == WILDCARD) || (rule_rd_q.src == req_src_q)) &&
		((rule_rd_q.dst == WILDCARD) || (rule_rd_q.dst == req_dst_q));
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);

	// Rule memory read address: rule 0 in idle, next rule while scanning on, else hold.
	logic [IDX_W-1:0] rd_addr;

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_IDLE) begin
			rd_addr = '0;
		end else if (state_q == S_SCAN && !rule_hit && !scan_last) begin
			rd_addr = idx_q + IDX_W'(1);
		end
	end

	// Table write on an add that fits.
	logic  add_we;
	rule_t add_entry;

	assign add_we            = in_fire && (s_tuser == OP_ADD) && !tbl_full;
	assign add_entry.dir     = in_dir;
	assign add_entry.verdict = (in_act == ACTION_BAD) ? VERDICT_ACCEPT : in_act;
	assign add_entry.src     = in_src;
	assign add_entry.dst     = in_dst;

	always_ff @(posedge clk) begin
		if (add_we) begin
			rule_mem[used_q[IDX_W-1:0]] <= add_entry;
		end
		rule_rd_q <= rule_mem[rd_addr];
	end

	// Hit counter memory: cleared on add, incremented on a match.
	logic               hit_we;
	logic [IDX_W-1:0]   hit_waddr;
	logic [COUNT_W-1:0] hit_wdata;
	logic [COUNT_W-1:0] hit_inc;

	assign hit_inc = hit_rd_q + COUNT_W'(1);

	always_comb begin
		hit_we    = 1'b0;
		hit_waddr = idx_q;
		hit_wdata = hit_inc;
		if (state_q == S_HIT) begin
			hit_we = 1'b1;
		end else if (add_we) begin
			hit_we    = 1'b1;
			hit_waddr = used_q[IDX_W-1:0];
			hit_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_we) begin
			hit_mem[hit_waddr] <= hit_wdata;
		end
		hit_rd_q <= hit_mem[idx_q];
	end

	// Totals after the pending result has been counted.
	logic               out_load;
	logic [COUNT_W-1:0] drop_nx;
	logic [COUNT_W-1:0] log_nx;
	logic [COUNT_W-1:0] accept_nx;

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		drop_nx   = drop_cnt_q;
		log_nx    = log_cnt_q;
		accept_nx = accept_cnt_q;
		if (res_check_q) begin
			case (res_verdict_q)
				VERDICT_DROP: drop_nx   = drop_cnt_q + COUNT_W'(1);
				VERDICT_LOG:  log_nx    = log_cnt_q + COUNT_W'(1);
				default:      accept_nx = accept_cnt_q + COUNT_W'(1);
			endcase
		end
	end

	// Result word assembly.
	logic [RIX_W-1:0]      res_idx_ext;
	logic [OUT_BITS-1:0]   out_word;

	assign res_idx_ext = RIX_W'(res_idx_q);
	assign out_word = {accept_nx, log_nx, drop_nx, res_hits_q,
		res_idx_ext[RULE_INDEX_W-1:0], res_matched_q, res_verdict_q, res_status_q};

	// Sequencer, table fill count and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			idx_q        <= '0;
			drop_cnt_q   <= '0;
			log_cnt_q    <= '0;
			accept_cnt_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						if (s_tuser == OP_ADD) begin
							if (!tbl_full) begin
								used_q <= used_q + CNT_W'(1);
							end
							state_q <= S_DONE;
						end else if (used_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rule_hit) begin
						state_q <= S_HIT;
					end else if (scan_last) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_HIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						drop_cnt_q   <= drop_nx;
						log_cnt_q    <= log_nx;
						accept_cnt_q <= accept_nx;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Output register valid.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request and pending result fields.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_dir_q     <= in_dir;
			req_src_q     <= in_src;
			req_dst_q     <= in_dst;
			res_check_q   <= (s_tuser == OP_CHECK);
			res_status_q  <= (s_tuser == OP_ADD && tbl_full) ? STATUS_FULL : STATUS_OK;
			res_verdict_q <= VERDICT_ACCEPT;
			res_matched_q <= 1'b0;
			res_idx_q     <= (s_tuser == OP_ADD && !tbl_full) ? used_q[IDX_W-1:0] : '0;
			res_hits_q    <= '0;
		end else if (state_q == S_SCAN && rule_hit) begin
			res_verdict_q <= rule_rd_q.verdict;
			res_matched_q <= 1'b1;
			res_idx_q     <= idx_q;
		end else if (state_q == S_HIT) begin
			res_hits_q <= hit_inc;
		end
	end

	// Output data register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= OUT_TDATA_W'(out_word);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks on the sequencer and the table.
	`FMRC_ASSERT_SAME(a_used_bound, 1'b1, used_q <= CNT_W'(MAX_RULES), "rule count overflow")
	`FMRC_ASSERT_SAME(a_scan_in_table, state_q == S_SCAN, CNT_W'(idx_q) < used_q,
		"scan index beyond filled table")
	`FMRC_ASSERT_NEXT(a_add_grows, add_we, used_q == $past(used_q) + CNT_W'(1),
		"add did not grow the table")
	`FMRC_ASSERT_SAME(a_hit_matched, state_q == S_HIT, res_matched_q,
		"hit update without a match")
	`FMRC_ASSERT_NEXT(a_result_out, out_load, m_tvalid, "result load lost")

endmodule

`default_nettype wire

// ===== tb/fmrc_checker.sv =====
// ----------------------------------------------------------------------------
// fmrc_checker
// Watches both word channels of the first-match rule classifier. It keeps its
// own copy of the rule table, hit counts and verdict totals, predicts the
// result word of every accepted input word, and compares each result word
// field by field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmrc_checker
	import fmrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	// tdata from bit 0: direction, action, source module, destination module,
	// zero pad.
	input  wire logic [23:0]           s_tdata,
	// tuser: op.
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	// tdata from bit 0: status, verdict, matched, rule_index, rule_hits,
	// dropped_total, logged_total, accepted_total, zero pad.
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	output int                         mismatches,
	output int                         pending
);

	localparam int MOD_W = MODULE_BITS_DEF + 1;
	localparam logic [MOD_W-1:0] ANY_MODULE = '1;

	// Result word as it sits on m_tdata, highest field first.
	typedef struct packed {
		logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
		logic [COUNT_W-1:0]              accepted_total, logged_total, dropped_total, rule_hits;
		logic [RULE_INDEX_W-1:0]         rule_index;
		logic                            matched;
		logic [1:0]                      verdict;
		logic                            status;
	} result_word_t;

	typedef struct {
		logic [1:0]       dir;
		logic [1:0]       verdict;
		logic [MOD_W-1:0] src;
		logic [MOD_W-1:0] dst;
		logic [31:0]      hits;
	} rule_t;

	// Predicted state of the block.
	rule_t        rules [MAX_RULES_DEF];
	int           rule_count;
	logic [31:0]  drop_total;
	logic [31:0]  log_total;
	logic [31:0]  accept_total;
	result_word_t awaited_results [$];
	result_word_t got;
	result_word_t want;

	initial mismatches = 0;
	initial pending = 0;

	// Applies one input word to the predicted table and returns its result word.
	function automatic result_word_t classify_word(input logic op, input logic [23:0] word);
		logic [1:0]       dir;
		logic [1:0]       act;
		logic [MOD_W-1:0] src;
		logic [MOD_W-1:0] dst;
		result_word_t     res;
		bit               found;
		dir = word[1:0];
		act = word[3:2];
		src = word[4 +: MOD_W];
		dst = word[4 + MOD_W +: MOD_W];
		res = '0;
		found = 1'b0;
		if (op == OP_ADD) begin
			if (rule_count >= MAX_RULES_DEF) begin
				res.status = STATUS_FULL;
			end else begin
				rules[rule_count].dir = dir;
				// An undefined action code is stored as accept.
				rules[rule_count].verdict = (act == ACTION_BAD) ? VERDICT_ACCEPT : act;
				rules[rule_count].src = src;
				rules[rule_count].dst = dst;
				rules[rule_count].hits = '0;
				res.rule_index = rule_count[RULE_INDEX_W-1:0];
				rule_count++;
			end
		end else begin
			// First rule in insertion order wins; no match means accept.
			for (int k = 0; k < rule_count && !found; k++) begin
				if ((rules[k].dir == DIR_BOTH || rules[k].dir == dir) &&
						(rules[k].src == ANY_MODULE || rules[k].src == src) &&
						(rules[k].dst == ANY_MODULE || rules[k].dst == dst)) begin
					found = 1'b1;
					rules[k].hits++;
					res.matched = 1'b1;
					res.rule_index = k[RULE_INDEX_W-1:0];
					res.rule_hits = rules[k].hits;
					res.verdict = rules[k].verdict;
				end
			end
			case (res.verdict)
				VERDICT_DROP: drop_total++;
				VERDICT_LOG:  log_total++;
				default:      accept_total++;
			endcase
		end
		res.dropped_total = drop_total;
		res.logged_total = log_total;
		res.accepted_total = accept_total;
		return res;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	// Result words are compared before the input word of the same edge is
	// predicted, so a stray result can never consume a fresh prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count = 0;
			drop_total = '0;
			log_total = '0;
			accept_total = '0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_word_t'(m_tdata);
				if (awaited_results.size() == 0) begin
					$display("%0t: result word with none expected, got %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					mismatches += field_differs("status", want.status, got.status);
					mismatches += field_differs("verdict", want.verdict, got.verdict);
					mismatches += field_differs("matched", want.matched, got.matched);
					mismatches += field_differs("rule_index", want.rule_index, got.rule_index);
					mismatches += field_differs("rule_hits", want.rule_hits, got.rule_hits);
					mismatches += field_differs("dropped_total", want.dropped_total,
						got.dropped_total);
					mismatches += field_differs("logged_total", want.logged_total,
						got.logged_total);
					mismatches += field_differs("accepted_total", want.accepted_total,
						got.accepted_total);
				end
			end
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(classify_word(s_tuser, s_tdata));
			end
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the first-match rule classifier. A directed opening covers the
// empty table, odd direction and action codes, wildcards and extreme module
// ids; random traffic then fills the table, keeps adding past full, and checks
// packets against it under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
	import fmrc_pkg::*;
();

	localparam int MOD_W = MODULE_BITS_DEF + 1;
	localparam logic [MOD_W-1:0] ANY_MODULE = '1;
	localparam logic [1:0] DIR_INGRESS = 2'd0;
	localparam logic [1:0] DIR_EGRESS  = 2'd1;
	localparam logic [1:0] DIR_ODD     = 2'd3;
	localparam int RANDOM_WORDS = 1780;
	localparam int PHASE_WORDS  = 150;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [23:0]            s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     mismatches;
	int                     pending;
	int                     idle_pct = 0;
	int                     stall_pct = 0;
	int                     words_sent = 0;
	int                     adds_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	first_match_rule_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fmrc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Receiver back-pressure at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one word, after random sender gaps, and returns at the edge that
	// accepts it.
	task automatic push_word(input logic op, input logic [1:0] dir, input logic [1:0] act,
			input logic [MOD_W-1:0] src, input logic [MOD_W-1:0] dst);
		case ((words_sent / PHASE_WORDS) % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 48; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 48; end
			default: begin idle_pct = 24; stall_pct = 24; end
		endcase
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, dst, src, act, dir};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (op == OP_ADD) adds_sent++;
	endtask

	// Rule module ids: wildcards often, a small pool for frequent hits.
	function automatic logic [MOD_W-1:0] rule_module();
		case ($urandom_range(7))
			0, 1:    return ANY_MODULE;
			2:       return MOD_W'($urandom_range(255));
			default: return MOD_W'($urandom_range(3));
		endcase
	endfunction

	function automatic logic [MOD_W-1:0] packet_module();
		case ($urandom_range(15))
			0:          return ANY_MODULE;
			1, 2, 3, 4: return MOD_W'($urandom_range(255));
			default:    return MOD_W'($urandom_range(3));
		endcase
	endfunction

	function automatic logic [1:0] random_dir();
		return ($urandom_range(19) == 0) ? DIR_ODD : 2'($urandom_range(2));
	endfunction

	initial begin
		logic add_now;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Checks against the empty table fall through to accept.
		push_word(OP_CHECK, DIR_INGRESS, VERDICT_ACCEPT, 9'd0, 9'd0);
		push_word(OP_CHECK, DIR_ODD, VERDICT_ACCEPT, 9'd255, ANY_MODULE);
		// A few rules with odd codes, wildcards and extreme ids.
		push_word(OP_ADD, DIR_ODD, VERDICT_DROP, 9'd5, 9'd6);
		push_word(OP_ADD, DIR_INGRESS, ACTION_BAD, 9'd0, 9'd255);
		push_word(OP_ADD, DIR_EGRESS, VERDICT_LOG, 9'd255, 9'd0);
		push_word(OP_ADD, DIR_BOTH, VERDICT_DROP, ANY_MODULE, 9'd7);
		push_word(OP_ADD, DIR_INGRESS, VERDICT_LOG, 9'd9, ANY_MODULE);
		push_word(OP_CHECK, DIR_ODD, ACTION_BAD, 9'd5, 9'd6);
		push_word(OP_CHECK, DIR_INGRESS, VERDICT_ACCEPT, 9'd5, 9'd6);
		push_word(OP_CHECK, DIR_INGRESS, VERDICT_ACCEPT, 9'd0, 9'd255);
		push_word(OP_CHECK, DIR_EGRESS, VERDICT_ACCEPT, 9'd255, 9'd0);
		push_word(OP_CHECK, DIR_ODD, VERDICT_ACCEPT, 9'd100, 9'd7);
		push_word(OP_CHECK, DIR_INGRESS, VERDICT_ACCEPT, 9'd9, 9'd200);
		push_word(OP_CHECK, DIR_EGRESS, VERDICT_ACCEPT, 9'd9, 9'd200);
		push_word(OP_CHECK, DIR_INGRESS, VERDICT_ACCEPT, ANY_MODULE, ANY_MODULE);
		push_word(OP_CHECK, DIR_INGRESS, VERDICT_ACCEPT, 9'd0, 9'd255);
		// A catch-all rule behind the others.
		push_word(OP_ADD, DIR_BOTH, VERDICT_ACCEPT, ANY_MODULE, ANY_MODULE);
		push_word(OP_CHECK, DIR_EGRESS, VERDICT_ACCEPT, 9'd1, 9'd2);

		// Random traffic: adds are frequent until the table is full, then rare.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (adds_sent < MAX_RULES_DEF)
				add_now = ($urandom_range(2) == 0);
			else
				add_now = ($urandom_range(19) == 0);
			if (add_now) begin
				push_word(OP_ADD, random_dir(),
					($urandom_range(9) == 0) ? ACTION_BAD : 2'($urandom_range(2)),
					rule_module(), rule_module());
			end else begin
				push_word(OP_CHECK, random_dir(), 2'($urandom_range(3)),
					packet_module(), packet_module());
			end
		end
		s_tvalid <= 1'b0;

		// Drain the outstanding results, then watch for stray words.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
